// File: rtl/core/srl_pkg.sv
// Shared types, constants and helper functions for the sorted record list block.
`default_nettype none
package srl_pkg;

   localparam int NUM_LISTS_DEF        = 10;
   localparam int POOL_ENTRIES_DEF     = 64;
   localparam int MAX_RECORD_WORDS_DEF = 8;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_PUT   = 2'd2,
      OP_GET   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_ERR = 2'd1,
      ST_EOD = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEC,
      S_FILL,
      S_ALLOC,
      S_CRD,
      S_CEV,
      S_WNXT,
      S_LNK2,
      S_GNXT,
      S_GRD,
      S_GOUT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic differ;
      logic greater;
   } cmp_res_type;

   // words needed for a byte length
   function automatic logic [4:0] words_of(input logic [6:0] len);
      logic [7:0] sum;
      sum = {1'b0, len} + 8'd7;
      return sum[7:3];
   endfunction

   // bytes of word w that lie inside a length of len bytes
   function automatic logic [63:0] byte_mask(input logic [6:0] len, input logic [5:0] w);
      logic [9:0]  start;
      logic [9:0]  nb;
      logic [3:0]  drop;
      logic [63:0] res;
      start = {1'b0, w, 3'b000};
      nb    = {3'b000, len} - start;
      drop  = 4'd8 - nb[3:0];
      if ({3'b000, len} <= start) begin
         res = 64'd0;
      end else if (nb >= 10'd8) begin
         res = {64{1'b1}};
      end else begin
         res = {64{1'b1}} << {drop[2:0], 3'b000};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/srl_rec_mem.sv
// Record word memory: one write port, two registered read ports.
`default_nettype none
module srl_rec_mem
   import srl_pkg::*;
#(
   parameter int DEPTH = POOL_ENTRIES_DEF * MAX_RECORD_WORDS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [63:0]   rd_data_a,
   output logic      [63:0]   rd_data_b
);

   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

// File: rtl/core/srl_link_mem.sv
// Node link memory: one write port, one registered read port.
`default_nettype none
module srl_link_mem
   import srl_pkg::*;
#(
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
   parameter int NW           = $clog2(POOL_ENTRIES),
   parameter int PW           = $clog2(POOL_ENTRIES + 1)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [NW-1:0] wr_addr,
   input  wire logic [PW-1:0] wr_data,
   input  wire logic [NW-1:0] rd_addr,
   output logic      [PW-1:0] rd_data
);

   logic [PW-1:0] mem [POOL_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/core/srl_key_cmp.sv
// Shared key comparator: one masked 64-bit key word per use.
`default_nettype none
module srl_key_cmp
   import srl_pkg::*;
(
   input  wire logic [63:0] word_a,
   input  wire logic [63:0] word_b,
   input  wire logic [6:0]  key_len,
   input  wire logic [5:0]  word_idx,
   output cmp_res_type      res
);

   logic [63:0] mask;
   logic [63:0] xa;
   logic [63:0] xb;

   always_comb begin
      mask        = byte_mask(key_len, word_idx);
      xa          = word_a & mask;
      xb          = word_b & mask;
      res.differ  = (xa != xb);
      res.greater = (xa > xb);
   end

endmodule
`default_nettype wire

// File: rtl/core/stable_sorted_record_lists.sv
// Top level: sorted record lists over a shared node pool, with command sequencer.
//
// Usage: one command item enters on the req_ channel (valid/stall); results leave on
// the rsp_ channel (valid/stall). Open, close and put give one result; get gives
// one result per record word, one end-of-data result on an empty list, or one
// error result on a bad list id. One item is worked on at a time; req_stall is
// high from acceptance until the item's last result has been loaded into the output
// register. Open, close and a non-final put word go from decode (S_DEC) to S_RESP,
// which loads the result. The final word of a put writes the remaining record words
// (one per cycle), then links the record: into an empty list directly, else by one
// tail compare and, if that fails, a walk from the head that compares key words one
// at a time (S_CRD, S_CEV) on the single record memory and shared key comparator,
// stepping nodes in S_WNXT. A get unlinks the head node (S_GNXT), then for each word
// reads it (S_GRD) and loads it into the output register (S_GOUT). Reset is
// synchronous; it clears all lists to closed and empty and the pool to all free.
// Record memory content is not cleared. When the receiver stalls, the result holds
// in the output register and the sequencer waits before producing the next one.
`default_nettype none
module stable_sorted_record_lists
   import srl_pkg::*;
#(
   parameter int NUM_LISTS        = NUM_LISTS_DEF,
   parameter int POOL_ENTRIES     = POOL_ENTRIES_DEF,
   parameter int MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_list_id,
   input  wire logic [6:0]  req_record_bytes,
   input  wire logic [6:0]  req_key_bytes,
   input  wire logic [63:0] req_data_word,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_out_word,
   output logic             rsp_word_valid,
   output logic             rsp_final_result
);

   localparam int NW  = $clog2(POOL_ENTRIES);
   localparam int PW  = $clog2(POOL_ENTRIES + 1);
   localparam int AW  = $clog2(POOL_ENTRIES * MAX_RECORD_WORDS);
   localparam int WCW = $clog2(MAX_RECORD_WORDS + 1);
   localparam int LIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

   state_type state_ff, state_in;

   op_type      op_ff;
   logic [3:0]  id_ff;
   logic [6:0]  rbytes_ff;
   logic [6:0]  kbytes_ff;
   logic [63:0] data_ff;
   logic        last_ff;

   logic [WCW-1:0] cc_ff, cc_in;
   logic [WCW-1:0] cw_ff, cw_in;
   logic [WCW-1:0] nw_ff, nw_in;
   logic [PW-1:0]  fhead_ff, fhead_in;
   logic [PW-1:0]  fresh_ff, fresh_in;
   logic [NW-1:0]  node_ff, node_in;
   logic [PW-1:0]  a_ff, a_in;
   logic [PW-1:0]  prev_ff, prev_in;
   logic [PW-1:0]  lnk_ff, lnk_in;
   logic           walk_ff, walk_in;
   status_type     st_ff, st_in;

   logic [PW-1:0] head_ff [NUM_LISTS];
   logic [PW-1:0] head_in [NUM_LISTS];
   logic [PW-1:0] tail_ff [NUM_LISTS];
   logic [PW-1:0] tail_in [NUM_LISTS];
   logic          open_ff [NUM_LISTS];
   logic          open_in [NUM_LISTS];
   logic [6:0]    lrec_ff [NUM_LISTS];
   logic [6:0]    lrec_in [NUM_LISTS];
   logic [6:0]    lkey_ff [NUM_LISTS];
   logic [6:0]    lkey_in [NUM_LISTS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic        rsp_wv_ff, rsp_wv_in;
   logic        rsp_fin_ff, rsp_fin_in;

   logic          rec_we;
   logic [AW-1:0] rec_waddr;
   logic [63:0]   rec_wdata;
   logic [AW-1:0] rec_raddr_a;
   logic [AW-1:0] rec_raddr_b;
   logic [63:0]   rec_q_a;
   logic [63:0]   rec_q_b;
   logic          nl_we;
   logic [NW-1:0] nl_waddr;
   logic [PW-1:0] nl_wdata;
   logic [NW-1:0] nl_raddr;
   logic [PW-1:0] nl_q;
   cmp_res_type   cmp;

   logic [LIW-1:0] lid;
   logic           valid_id;
   logic [PW-1:0]  cur_head;
   logic [PW-1:0]  cur_tail;
   logic           cur_open;
   logic [6:0]     cur_rlen;
   logic [6:0]     cur_klen;
   logic [4:0]     rec_words;
   logic [4:0]     key_words;
   logic [WCW-1:0] nw_cur;
   logic           too_long;
   logic           pool_full;
   logic           put_err;
   logic [NW-1:0]  alloc_node;
   logic           out_free;
   logic           key_end;
   logic           gout_last;

   always_comb begin
      lid        = id_ff[LIW-1:0];
      valid_id   = ({1'b0, id_ff} < 5'(NUM_LISTS));
      cur_head   = head_ff[lid];
      cur_tail   = tail_ff[lid];
      cur_open   = open_ff[lid];
      cur_rlen   = lrec_ff[lid];
      cur_klen   = lkey_ff[lid];
      rec_words  = words_of(cur_rlen);
      key_words  = words_of(cur_klen);
      nw_cur     = (8'(rec_words) > 8'(MAX_RECORD_WORDS)) ? WCW'(MAX_RECORD_WORDS)
                                                          : WCW'(rec_words);
      too_long   = ({3'b000, cur_rlen} > 10'(MAX_RECORD_WORDS * 8));
      pool_full  = (fhead_ff == NIL) && (fresh_ff == PW'(POOL_ENTRIES));
      put_err    = !valid_id || !cur_open || pool_full || too_long;
      alloc_node = (fhead_ff != NIL) ? fhead_ff[NW-1:0] : fresh_ff[NW-1:0];
      out_free   = !rsp_valid_ff || !rsp_stall;
      key_end    = (8'(cw_ff) >= 8'(key_words));
      gout_last  = (8'(cw_ff) + 8'd1 == 8'(nw_ff));
      rec_raddr_a = AW'(a_ff[NW-1:0]) * AW'(MAX_RECORD_WORDS) + AW'(cw_ff);
      rec_raddr_b = AW'(node_ff) * AW'(MAX_RECORD_WORDS) + AW'(cw_ff);
   end

   srl_rec_mem #(
      .DEPTH (POOL_ENTRIES * MAX_RECORD_WORDS),
      .AW    (AW)
   ) u_rec_mem (
      .clock     (clock),
      .wr_en     (rec_we),
      .wr_addr   (rec_waddr),
      .wr_data   (rec_wdata),
      .rd_addr_a (rec_raddr_a),
      .rd_addr_b (rec_raddr_b),
      .rd_data_a (rec_q_a),
      .rd_data_b (rec_q_b)
   );

   srl_link_mem #(
      .POOL_ENTRIES (POOL_ENTRIES),
      .NW           (NW),
      .PW           (PW)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (nl_we),
      .wr_addr (nl_waddr),
      .wr_data (nl_wdata),
      .rd_addr (nl_raddr),
      .rd_data (nl_q)
   );

   srl_key_cmp u_key_cmp (
      .word_a   (rec_q_a),
      .word_b   (rec_q_b),
      .key_len  (cur_klen),
      .word_idx (6'(cw_ff)),
      .res      (cmp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_RESP;
            if (op_ff == OP_PUT && !put_err && last_ff) begin
               state_in = S_FILL;
            end else if (op_ff == OP_GET && valid_id && cur_head != NIL) begin
               state_in = S_GNXT;
            end
         end
         S_FILL: begin
            if (cc_ff >= nw_ff) state_in = S_ALLOC;
         end
         S_ALLOC: begin
            state_in = (cur_head == NIL) ? S_RESP : S_CRD;
         end
         S_CRD: begin
            if (!key_end) begin
               state_in = S_CEV;
            end else if (!walk_ff) begin
               state_in = S_LNK2;
            end else begin
               state_in = S_WNXT;
            end
         end
         S_CEV: begin
            if (!cmp.differ) begin
               state_in = S_CRD;
            end else if (!walk_ff && !cmp.greater) begin
               state_in = S_LNK2;
            end else if (!walk_ff) begin
               state_in = S_CRD;
            end else if (cmp.greater) begin
               state_in = S_LNK2;
            end else begin
               state_in = S_WNXT;
            end
         end
         S_WNXT: begin
            state_in = (nl_q == NIL) ? S_LNK2 : S_CRD;
         end
         S_LNK2: state_in = S_RESP;
         S_GNXT: state_in = (nw_ff == '0) ? S_RESP : S_GRD;
         S_GRD:  state_in = S_GOUT;
         S_GOUT: begin
            if (out_free) state_in = gout_last ? S_IDLE : S_GRD;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic cmp_done;
      logic cmp_gt;
      cc_in    = cc_ff;
      cw_in    = cw_ff;
      nw_in    = nw_ff;
      fhead_in = fhead_ff;
      fresh_in = fresh_ff;
      node_in  = node_ff;
      a_in     = a_ff;
      prev_in  = prev_ff;
      lnk_in   = lnk_ff;
      walk_in  = walk_ff;
      st_in    = st_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      open_in  = open_ff;
      lrec_in  = lrec_ff;
      lkey_in  = lkey_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_wv_in     = rsp_wv_ff;
      rsp_fin_in    = rsp_fin_ff;
      rec_we    = 1'b0;
      rec_waddr = AW'(alloc_node) * AW'(MAX_RECORD_WORDS) + AW'(cc_ff);
      rec_wdata = 64'd0;
      nl_we     = 1'b0;
      nl_waddr  = node_ff;
      nl_wdata  = NIL;
      nl_raddr  = a_ff[NW-1:0];
      cmp_done  = (state_ff == S_CRD && key_end) || (state_ff == S_CEV && cmp.differ);
      cmp_gt    = (state_ff == S_CEV) && cmp.greater;

      case (state_ff)
         S_DEC: begin
            st_in = ST_OK;
            if (op_ff != OP_PUT) cc_in = '0;
            case (op_ff)
               OP_OPEN, OP_CLOSE: begin
                  if (!valid_id) begin
                     st_in = ST_ERR;
                  end else begin
                     if (cur_open && cur_head != NIL) begin
                        nl_we    = 1'b1;
                        nl_waddr = cur_tail[NW-1:0];
                        nl_wdata = fhead_ff;
                        fhead_in = cur_head;
                     end
                     head_in[lid] = NIL;
                     tail_in[lid] = NIL;
                     open_in[lid] = (op_ff == OP_OPEN);
                     if (op_ff == OP_OPEN) begin
                        lrec_in[lid] = rbytes_ff;
                        lkey_in[lid] = (kbytes_ff < rbytes_ff) ? kbytes_ff : rbytes_ff;
                     end
                  end
               end
               OP_PUT: begin
                  if (put_err) begin
                     cc_in = '0;
                     st_in = ST_ERR;
                  end else begin
                     nw_in = nw_cur;
                     if (cc_ff < nw_cur) begin
                        rec_we    = 1'b1;
                        rec_wdata = data_ff & byte_mask(cur_rlen, 6'(cc_ff));
                        cc_in     = cc_ff + 1'b1;
                     end
                  end
               end
               OP_GET: begin
                  if (!valid_id) begin
                     st_in = ST_ERR;
                  end else if (cur_head == NIL) begin
                     st_in = ST_EOD;
                  end else begin
                     nw_in    = nw_cur;
                     node_in  = cur_head[NW-1:0];
                     a_in     = cur_head;
                     nl_raddr = cur_head[NW-1:0];
                  end
               end
               default: st_in = ST_ERR;
            endcase
         end
         S_FILL: begin
            nl_raddr = fhead_ff[NW-1:0];
            if (cc_ff < nw_ff) begin
               rec_we = 1'b1;
               cc_in  = cc_ff + 1'b1;
            end
         end
         S_ALLOC: begin
            node_in = alloc_node;
            cc_in   = '0;
            cw_in   = '0;
            walk_in = 1'b0;
            a_in    = cur_tail;
            if (fhead_ff != NIL) begin
               fhead_in = nl_q;
            end else begin
               fresh_in = fresh_ff + 1'b1;
            end
            if (cur_head == NIL) begin
               head_in[lid] = PW'(alloc_node);
               tail_in[lid] = PW'(alloc_node);
               nl_we        = 1'b1;
               nl_waddr     = alloc_node;
               nl_wdata     = NIL;
            end
         end
         S_CRD, S_CEV: begin
            if (state_ff == S_CEV && !cmp.differ) cw_in = cw_ff + 1'b1;
            if (cmp_done && !walk_ff) begin
               if (!cmp_gt) begin
                  nl_we    = 1'b1;
                  nl_waddr = a_ff[NW-1:0];
                  nl_wdata = PW'(node_ff);
                  lnk_in   = NIL;
               end else begin
                  walk_in = 1'b1;
                  a_in    = cur_head;
                  prev_in = NIL;
                  cw_in   = '0;
               end
            end else if (cmp_done) begin
               if (cmp_gt) begin
                  lnk_in = a_ff;
                  if (prev_ff == NIL) begin
                     head_in[lid] = PW'(node_ff);
                  end else begin
                     nl_we    = 1'b1;
                     nl_waddr = prev_ff[NW-1:0];
                     nl_wdata = PW'(node_ff);
                  end
               end else begin
                  prev_in  = a_ff;
                  nl_raddr = a_ff[NW-1:0];
               end
            end
         end
         S_WNXT: begin
            a_in  = nl_q;
            cw_in = '0;
            if (nl_q == NIL) begin
               lnk_in   = NIL;
               nl_we    = 1'b1;
               nl_waddr = prev_ff[NW-1:0];
               nl_wdata = PW'(node_ff);
            end
         end
         S_LNK2: begin
            nl_we    = 1'b1;
            nl_waddr = node_ff;
            nl_wdata = lnk_ff;
            st_in    = ST_OK;
            if (lnk_ff == NIL) tail_in[lid] = PW'(node_ff);
         end
         S_GNXT: begin
            head_in[lid] = nl_q;
            if (nl_q == NIL) tail_in[lid] = NIL;
            nl_we    = 1'b1;
            nl_waddr = node_ff;
            nl_wdata = fhead_ff;
            fhead_in = PW'(node_ff);
            cw_in    = '0;
            st_in    = ST_OK;
         end
         S_GOUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_word_in   = rec_q_a;
               rsp_wv_in     = 1'b1;
               rsp_fin_in    = gout_last;
               cw_in         = cw_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_word_in   = 64'd0;
               rsp_wv_in     = 1'b0;
               rsp_fin_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cc_ff        <= '0;
         fhead_ff     <= NIL;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
            open_ff[i] <= 1'b0;
            lrec_ff[i] <= 7'd0;
            lkey_ff[i] <= 7'd0;
         end
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         fhead_ff     <= fhead_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         open_ff      <= open_in;
         lrec_ff      <= lrec_in;
         lkey_ff      <= lkey_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff     <= op_type'(req_opcode);
         id_ff     <= req_list_id;
         rbytes_ff <= req_record_bytes;
         kbytes_ff <= req_key_bytes;
         data_ff   <= req_data_word;
         last_ff   <= req_last_word;
      end
      cw_ff         <= cw_in;
      nw_ff         <= nw_in;
      node_ff       <= node_in;
      a_ff          <= a_in;
      prev_ff       <= prev_in;
      lnk_ff        <= lnk_in;
      walk_ff       <= walk_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_word     = rsp_word_ff;
   assign rsp_word_valid   = rsp_wv_ff;
   assign rsp_final_result = rsp_fin_ff;

   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= PW'(POOL_ENTRIES))
      else $error("fresh node count beyond pool size");

   a_alloc_node: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC |=> PW'(node_ff) < PW'(POOL_ENTRIES))
      else $error("allocated node outside pool");

   a_get_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GOUT && out_free) |=> (rsp_valid_ff && rsp_wv_ff))
      else $error("record word not presented");

   a_accept_dec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_DEC)
      else $error("accepted item not decoded");

endmodule
`default_nettype wire

// File: sim/stable_sorted_record_lists_tb.sv
// Self-checking testbench for the sorted record lists block: predicts every result.
`default_nettype none
module stable_sorted_record_lists_tb;
   import srl_pkg::*;

   localparam int LISTS = 10;
   localparam int POOL  = 64;
   localparam int MAXW  = 8;
   localparam int NIL   = POOL;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] word;
      logic        word_valid;
      logic        final_result;
   } rsp_item_type;

   class record_list_board;
      logic [63:0]  store [POOL*MAXW];
      int           link [POOL];
      int           free_head;
      int           head [LISTS];
      int           tail [LISTS];
      bit           is_open [LISTS];
      int           rec_len [LISTS];
      int           key_len [LISTS];
      int           collected;
      rsp_item_type pending_rsp [$];
      int           errors;

      function new();
         for (int i = 0; i < POOL*MAXW; i++) store[i] = '0;
         for (int i = 0; i < POOL; i++) link[i] = i + 1;
         free_head = 0;
         for (int i = 0; i < LISTS; i++) begin
            head[i] = NIL; tail[i] = NIL; is_open[i] = 0; rec_len[i] = 0; key_len[i] = 0;
         end
         collected = 0;
         errors = 0;
      endfunction

      function logic [63:0] lane_mask(int len, int w);
         int nb;
         if (len <= w*8) return '0;
         nb = len - w*8;
         if (nb >= 8) return '1;
         return {64{1'b1}} << (8*(8-nb));
      endfunction

      function int key_order(int a, int b, int klen);
         logic [63:0] x, y, m;
         for (int w = 0; w < (klen+7)/8 && w < MAXW; w++) begin
            m = lane_mask(klen, w);
            x = store[a*MAXW+w] & m;
            y = store[b*MAXW+w] & m;
            if (x < y) return -1;
            if (x > y) return 1;
         end
         return 0;
      endfunction

      function void free_node(int n);
         link[n] = free_head;
         free_head = n;
      endfunction

      function void drop_list(int id);
         int n, guard;
         guard = 0;
         if (is_open[id]) begin
            while (head[id] < NIL && guard < POOL) begin
               n = head[id];
               head[id] = link[n];
               free_node(n);
               guard++;
            end
            head[id] = NIL; tail[id] = NIL; is_open[id] = 0;
         end
      endfunction

      function void insert_sorted(int id, int node);
         int pos, prev, guard;
         prev = NIL; guard = 0;
         if (head[id] >= NIL) begin
            head[id] = node; tail[id] = node; link[node] = NIL;
            return;
         end
         if (key_order(tail[id], node, key_len[id]) <= 0) begin
            link[tail[id]] = node; link[node] = NIL; tail[id] = node;
            return;
         end
         pos = head[id];
         while (pos < NIL && guard < POOL) begin
            if (key_order(pos, node, key_len[id]) > 0) break;
            prev = pos; pos = link[pos]; guard++;
         end
         if (prev >= NIL) head[id] = node;
         else link[prev] = node;
         link[node] = pos;
         if (pos >= NIL) tail[id] = node;
      endfunction

      function void push_rsp(status_type st, logic [63:0] w, bit v, bit f);
         rsp_item_type r;
         r.status = st; r.word = w; r.word_valid = v; r.final_result = f;
         pending_rsp.push_back(r);
      endfunction

      function void note_item(op_type op, int id, int rb, int kb, logic [63:0] data, bit last);
         int len, nw, node;
         bit ok_id;
         ok_id = id < LISTS;
         if (op != OP_PUT) collected = 0;
         case (op)
            OP_OPEN: begin
               if (!ok_id) begin push_rsp(ST_ERR, '0, 0, 1); return; end
               drop_list(id);
               is_open[id] = 1; rec_len[id] = rb; key_len[id] = kb < rb ? kb : rb;
               head[id] = NIL; tail[id] = NIL;
               push_rsp(ST_OK, '0, 0, 1);
            end
            OP_CLOSE: begin
               if (!ok_id) begin push_rsp(ST_ERR, '0, 0, 1); return; end
               drop_list(id);
               push_rsp(ST_OK, '0, 0, 1);
            end
            OP_PUT: begin
               if (!ok_id || !is_open[id] || free_head >= NIL || rec_len[id] > MAXW*8) begin
                  collected = 0;
                  push_rsp(ST_ERR, '0, 0, 1);
                  return;
               end
               len = rec_len[id]; nw = (len+7)/8; node = free_head;
               if (collected < nw) begin
                  store[node*MAXW+collected] = data & lane_mask(len, collected);
                  collected++;
               end
               if (last) begin
                  while (collected < nw) begin
                     store[node*MAXW+collected] = '0;
                     collected++;
                  end
                  free_head = link[node];
                  insert_sorted(id, node);
                  collected = 0;
               end
               push_rsp(ST_OK, '0, 0, 1);
            end
            default: begin
               if (!ok_id) begin push_rsp(ST_ERR, '0, 0, 1); return; end
               node = head[id];
               if (node >= NIL) begin push_rsp(ST_EOD, '0, 0, 1); return; end
               nw = (rec_len[id]+7)/8;
               if (nw > MAXW) nw = MAXW;
               if (nw == 0) push_rsp(ST_OK, '0, 0, 1);
               for (int w = 0; w < nw; w++) push_rsp(ST_OK, store[node*MAXW+w], 1, w+1 == nw);
               head[id] = link[node];
               if (head[id] >= NIL) begin head[id] = NIL; tail[id] = NIL; end
               free_node(node);
            end
         endcase
      endfunction

      function void check_result(logic [1:0] st, logic [63:0] w, logic v, logic f);
         rsp_item_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status=%0d word=%h", $time, st, w);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (st !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
         end
         if (w !== e.word) begin
            $display("%0t: out_word exp %h got %h", $time, e.word, w); errors++;
         end
         if (v !== e.word_valid) begin
            $display("%0t: word_valid exp %0b got %0b", $time, e.word_valid, v); errors++;
         end
         if (f !== e.final_result) begin
            $display("%0t: final_result exp %0b got %0b", $time, e.final_result, f); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [3:0]  req_list_id;
   logic [6:0]  req_record_bytes;
   logic [6:0]  req_key_bytes;
   logic [63:0] req_data_word;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_out_word;
   logic        rsp_word_valid;
   logic        rsp_final_result;

   record_list_board board;
   int  items_sent;
   bit  hold_request;

   stable_sorted_record_lists u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_list_id(req_list_id),
      .req_record_bytes(req_record_bytes), .req_key_bytes(req_key_bytes),
      .req_data_word(req_data_word), .req_last_word(req_last_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_out_word(rsp_out_word),
      .rsp_word_valid(rsp_word_valid), .rsp_final_result(rsp_final_result)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("stable_sorted_record_lists test failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] key_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0) w[63:48] = 16'($urandom_range(0, 2));
      return w;
   endfunction

   task automatic send(op_type op, int id, int rb, int kb, logic [63:0] data, bit last);
      int gap;
      req_opcode       <= op;
      req_list_id      <= 4'(id);
      req_record_bytes <= 7'(rb);
      req_key_bytes    <= 7'(kb);
      req_data_word    <= data;
      req_last_word    <= last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_item(op, id, rb, kb, data, last);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_record(int id, int nbytes);
      int nw;
      nw = (nbytes + 7) / 8;
      if (nw == 0) nw = 1;
      for (int w = 0; w < nw; w++) send(OP_PUT, id, 0, 0, key_word(), w == nw - 1);
   endtask

   // receiver: random stalls, plus long holds on request
   initial begin
      int stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_status, rsp_out_word, rsp_word_valid, rsp_final_result);
         if (hold_request) begin
            hold_request = 0;
            stall_left = 400;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int id, r, guard;
      board            = new();
      items_sent       = 0;
      hold_request     = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_list_id      = '0;
      req_record_bytes = '0;
      req_key_bytes    = '0;
      req_data_word    = '0;
      req_last_word    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send(OP_OPEN, 15, 8, 8, '0, 0);
      send(OP_CLOSE, 12, 0, 0, '0, 0);
      send(OP_GET, 10, 0, 0, '0, 0);
      send(OP_PUT, 11, 0, 0, '1, 1);
      send(OP_CLOSE, 0, 0, 0, '0, 0);
      send(OP_PUT, 0, 0, 0, '1, 1);
      send(OP_GET, 0, 0, 0, '0, 0);
      send(OP_OPEN, 0, 20, 127, '0, 0);
      send(OP_PUT, 0, 0, 0, '1, 0);
      send(OP_PUT, 0, 0, 0, '1, 0);
      send(OP_PUT, 0, 0, 0, '1, 1);
      send(OP_PUT, 0, 0, 0, '0, 1);
      send(OP_GET, 0, 0, 0, '0, 0);
      send(OP_OPEN, 1, 0, 0, '0, 0);
      send(OP_PUT, 1, 0, 0, '1, 1);
      send(OP_GET, 1, 0, 0, '0, 0);
      send(OP_OPEN, 2, 127, 64, '0, 0);
      send(OP_PUT, 2, 0, 0, '1, 1);
      send(OP_OPEN, 3, 12, 4, '0, 0);
      send(OP_PUT, 3, 0, 0, 64'h0123456789abcdef, 0);
      send(OP_PUT, 0, 0, 0, 64'hfedcba9876543210, 1);
      send(OP_PUT, 3, 0, 0, '1, 0);
      send(OP_GET, 3, 0, 0, '0, 0);
      send(OP_PUT, 3, 0, 0, 64'h5555aaaa5555aaaa, 0);
      send(OP_PUT, 3, 0, 0, '1, 0);
      send(OP_PUT, 3, 0, 0, '1, 1);

      // fill the pool, then overflow
      send(OP_OPEN, 9, 8, 2, '0, 0);
      guard = 0;
      while (board.free_head < NIL && guard < 80) begin
         send(OP_PUT, 9, 0, 0, key_word(), 1);
         guard++;
      end
      send(OP_PUT, 9, 0, 0, key_word(), 1);
      send(OP_CLOSE, 9, 0, 0, '0, 0);
      for (int i = 0; i < 4; i++) send(OP_OPEN, i, $urandom_range(1, 24), $urandom_range(0, 16), '0, 0);

      while (items_sent < 310) begin
         if (items_sent > 150 && items_sent < 160) hold_request = 1;
         if (items_sent > 250 && items_sent < 256) begin
            req_valid <= 1'b0;
            while (board.pending_rsp.size() != 0) @(posedge clock);
         end
         id = $urandom_range(0, 3);
         r  = $urandom_range(0, 99);
         if (r < 45) begin
            if (board.is_open[id]) put_record(id, board.rec_len[id]);
         end else if (r < 70) begin
            send(OP_GET, id, 0, 0, '0, 0);
         end else if (r < 77) begin
            if ($urandom_range(0, 9) == 0)
               send(OP_OPEN, id, $urandom_range(0, 127), $urandom_range(0, 127), '0, 0);
            else
               send(OP_OPEN, id, $urandom_range(1, 24), $urandom_range(0, 24), '0, 0);
         end else if (r < 81) begin
            send(OP_CLOSE, $urandom_range(0, 15), 0, 0, '0, 0);
         end else if (r < 90) begin
            send(OP_PUT, id, 0, 0, key_word(), 0);
            send(op_type'($urandom_range(0, 3)), $urandom_range(0, 15), 0, 0, key_word(),
                 $urandom_range(0, 1));
         end else begin
            send(op_type'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 127),
                 $urandom_range(0, 127), {$urandom, $urandom}, $urandom_range(0, 1));
         end
      end
      req_valid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("stable_sorted_record_lists test passed");
      end else begin
         $display("stable_sorted_record_lists test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: stable_sorted_record_lists.f
rtl/core/srl_pkg.sv
rtl/core/srl_rec_mem.sv
rtl/core/srl_link_mem.sv
rtl/core/srl_key_cmp.sv
rtl/core/stable_sorted_record_lists.sv
sim/stable_sorted_record_lists_tb.sv
